[hdl/mabf_pkg.sv]
// Types, constants and helpers shared by the Modbus ASCII frame builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package mabf_pkg;

  localparam int FrameLen = 17;
  localparam int IdxW     = $clog2(FrameLen);
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  // frame positions
  localparam logic [IdxW-1:0] IDX_START     = IdxW'(0);
  localparam logic [IdxW-1:0] IDX_FIRST_HEX = IdxW'(1);
  localparam logic [IdxW-1:0] IDX_LAST_HEX  = IdxW'(14);
  localparam logic [IdxW-1:0] IDX_END_FIRST = IdxW'(15);
  localparam logic [IdxW-1:0] IDX_LAST      = IdxW'(FrameLen - 1);

  typedef enum logic [1:0] {
    REG_START_CHAR      = 2'd0,
    REG_END_CHAR_FIRST  = 2'd1,
    REG_END_CHAR_SECOND = 2'd2,
    REG_FORCE_BIT7      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] start_char;
    logic [6:0] end_char_first;
    logic [6:0] end_char_second;
    logic       force_bit7;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } byte_t;

  // upper-case ASCII hex digit, 7 bits
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = 7'h30 + n7;
    end else begin
      hex_char = 7'h37 + n7;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/mabf_cfg.sv]
// APB-style register file for the frame builder: start, terminators, bit-7 force.
// Depends on mabf_pkg.
`default_nettype none

module mabf_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mabf_pkg::AddrW-1:0] paddr,
  input  wire logic [mabf_pkg::DataW-1:0] pwdata,
  output logic      [mabf_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output mabf_pkg::cfg_t                 cfg
);
  import mabf_pkg::*;

  reg_idx_t sel;
  logic     wr;

  assign sel    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_char      <= 7'd58;
      cfg.end_char_first  <= 7'd13;
      cfg.end_char_second <= 7'd10;
      cfg.force_bit7      <= 1'b1;
    end else if (wr) begin
      case (sel)
        REG_START_CHAR:      cfg.start_char      <= pwdata[6:0];
        REG_END_CHAR_FIRST:  cfg.end_char_first  <= pwdata[6:0];
        REG_END_CHAR_SECOND: cfg.end_char_second <= pwdata[6:0];
        REG_FORCE_BIT7:      cfg.force_bit7      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_START_CHAR:      prdata = {25'd0, cfg.start_char};
      REG_END_CHAR_FIRST:  prdata = {25'd0, cfg.end_char_first};
      REG_END_CHAR_SECOND: prdata = {25'd0, cfg.end_char_second};
      REG_FORCE_BIT7:      prdata = {31'd0, cfg.force_bit7};
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/mabf_enc.sv]
// Command register, LRC and byte sequencer: turns one command into 17 frame bytes.
// Depends on mabf_pkg.
`default_nettype none

module mabf_enc (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     node_id,
  input  wire logic [7:0]     function_code,
  input  wire logic [15:0]    register_address,
  input  wire logic [15:0]    register_value,
  input  mabf_pkg::cfg_t      cfg,
  output logic                byte_valid,
  input  wire logic           byte_take,
  output mabf_pkg::byte_t     byte_out
);
  import mabf_pkg::*;

  // held command: six binary bytes followed by the LRC
  logic [55:0]     cmd;
  logic            busy;
  logic [IdxW-1:0] idx;

  logic [7:0]      sum;
  logic [7:0]      lrc_next;
  logic            accept;
  logic [3:0]      nib_sel;
  logic [3:0]      nib;
  logic [6:0]      ch;

  assign sum = node_id + function_code + register_address[15:8] + register_address[7:0]
             + register_value[15:8] + register_value[7:0];
  assign lrc_next = 8'd0 - sum;

  assign in_stall = busy && !(byte_take && idx == IDX_LAST);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_START;
    end else if (accept) begin
      busy <= 1'b1;
      idx  <= IDX_START;
    end else if (byte_take) begin
      if (idx == IDX_LAST) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= {node_id, function_code, register_address, register_value, lrc_next};
    end
  end

  // hex digits walk the held command high nibble first
  assign nib_sel = 4'(idx - IDX_FIRST_HEX);
  assign nib     = 4'(cmd >> (7'd52 - {1'b0, nib_sel, 2'b00}));

  always_comb begin
    if (idx == IDX_START) begin
      ch = cfg.start_char;
    end else if (idx <= IDX_LAST_HEX) begin
      ch = hex_char(nib);
    end else if (idx == IDX_END_FIRST) begin
      ch = cfg.end_char_first;
    end else begin
      ch = cfg.end_char_second;
    end
  end

  assign byte_valid          = busy;
  assign byte_out.frame_byte = {cfg.force_bit7, ch};
  assign byte_out.last_byte  = (idx == IDX_LAST);

endmodule

`default_nettype wire

[hdl/modbus_ascii_frame_builder_top.sv]
// Top level of the Modbus ASCII frame builder: register file, sequencer, output register.
// Depends on mabf_pkg, mabf_cfg and mabf_enc.
`default_nettype none

// Each accepted command yields a 17-word Modbus ASCII frame on the output
// channel: start character, twelve hex digits (node, function, address, value),
// two LRC digits and two terminators, last_byte marking the final word. The
// output byte counter sends one word per cycle while out_stall is low; the next
// command is taken in the cycle its predecessor's last word moves to the output
// register, so frames stream with no gap. The first word appears once acceptance
// has set the sequencer busy and the word has been loaded into the output
// register. Configure only while no frame is in flight.
module modbus_ascii_frame_builder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  node_id,
  input  wire logic [7:0]  function_code,
  input  wire logic [15:0] register_address,
  input  wire logic [15:0] register_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic             last_byte
);
  import mabf_pkg::*;

  cfg_t  cfg;
  byte_t enc_byte;
  logic  enc_valid;
  logic  take;

  mabf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mabf_enc u_enc (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .node_id          (node_id),
    .function_code    (function_code),
    .register_address (register_address),
    .register_value   (register_value),
    .cfg              (cfg),
    .byte_valid       (enc_valid),
    .byte_take        (take),
    .byte_out         (enc_byte)
  );

  assign take = enc_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= enc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_byte <= enc_byte.frame_byte;
      last_byte  <= enc_byte.last_byte;
    end
  end

endmodule

`default_nettype wire
